/* hdl/snp_pkg.sv */
// Shared types, codes and character helpers for the signed numeral parser.
package snp_pkg;

  // Parser phases, one-hot.
  typedef enum logic [6:0] {
    PH_LEAD     = 7'b000_0001,
    PH_SIGNED   = 7'b000_0010,
    PH_ZERO     = 7'b000_0100,
    PH_HEXSTART = 7'b000_1000,
    PH_HEX      = 7'b001_0000,
    PH_DEC      = 7'b010_0000,
    PH_TRAIL    = 7'b100_0000
  } phase_t;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HEXRANGE = 2'd1;
  localparam logic [1:0] ST_DECOVF   = 2'd2;
  localparam logic [1:0] ST_BAD      = 2'd3;

  // Input kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // Magnitude limits.
  localparam logic [63:0] POS_LIMIT   = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT   = 64'h8000_0000_0000_0000;
  localparam logic [63:0] DEC_LIMIT10 = 64'd922337203685477580;

  typedef struct packed {
    phase_t      phase;
    logic        negative;
    logic [63:0] magnitude;
    logic [1:0]  error_code;
  } parse_state_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  // Digit value of a hex character; meaningful only when is_hex holds.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] t;
    if (is_dec(c)) begin
      t = c - 8'h30;
    end else if (c >= 8'h61) begin
      t = c - 8'h57;
    end else begin
      t = c - 8'h37;
    end
    return t[3:0];
  endfunction

endpackage

/* hdl/snp_char_step.sv */
// Next parser state for one character beat.
module snp_char_step (
  input  snp_pkg::parse_state_t cur,
  input  logic [7:0]            char_code,
  output snp_pkg::parse_state_t nxt
);

  logic [3:0]  dig;
  logic [3:0]  dec_last;
  logic        dec_ovf;
  logic [63:0] dec_mag;
  logic [63:0] hex_mag;
  logic        hex_ovf;
  logic        sp;
  logic        dd;
  logic        hx;

  assign sp  = snp_pkg::is_space(char_code);
  assign dd  = snp_pkg::is_dec(char_code);
  assign hx  = snp_pkg::is_hex(char_code);
  assign dig = snp_pkg::hex_val(char_code);

  // Decimal: m*10 + d as two shifts and two adds, guarded by m vs floor(limit/10).
  assign dec_last = 4'd7 + {3'd0, cur.negative};
  assign dec_ovf  = (cur.magnitude >= snp_pkg::DEC_LIMIT10) &&
                    ((cur.magnitude > snp_pkg::DEC_LIMIT10) || (dig > dec_last));
  assign dec_mag  = {cur.magnitude[60:0], 3'd0} + {cur.magnitude[62:0], 1'b0} +
                    {60'd0, dig};

  // Hex: shift in a nibble; top nibble must be clear, then check the limit.
  assign hex_mag = {cur.magnitude[59:0], dig};
  always_comb begin
    if (cur.magnitude[63:60] != 4'd0) begin
      hex_ovf = 1'b1;
    end else if (cur.negative) begin
      hex_ovf = hex_mag > snp_pkg::NEG_LIMIT;
    end else begin
      hex_ovf = hex_mag > snp_pkg::POS_LIMIT;
    end
  end

  always_comb begin
    logic take_dec;
    logic take_hex;
    logic bad;
    nxt      = cur;
    take_dec = 1'b0;
    take_hex = 1'b0;
    bad      = 1'b0;
    case (cur.phase)
      snp_pkg::PH_LEAD, snp_pkg::PH_SIGNED: begin
        if (cur.phase == snp_pkg::PH_LEAD && sp) begin
          nxt.phase = cur.phase;
        end else if (cur.phase == snp_pkg::PH_LEAD &&
                     (char_code == 8'h2B || char_code == 8'h2D)) begin
          nxt.negative = (char_code == 8'h2D);
          nxt.phase    = snp_pkg::PH_SIGNED;
        end else if (char_code == 8'h30) begin
          nxt.phase = snp_pkg::PH_ZERO;
        end else if (dd) begin
          take_dec = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      snp_pkg::PH_ZERO: begin
        if (char_code == 8'h78 || char_code == 8'h58) begin
          nxt.phase = snp_pkg::PH_HEXSTART;
        end else if (dd) begin
          take_dec = 1'b1;
        end else if (sp) begin
          nxt.phase = snp_pkg::PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      snp_pkg::PH_HEXSTART: begin
        if (hx) begin
          take_hex = 1'b1;
        end else begin
          bad = 1'b1;
        end
      end
      snp_pkg::PH_HEX: begin
        if (hx) begin
          take_hex = 1'b1;
        end else if (sp) begin
          nxt.phase = snp_pkg::PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      snp_pkg::PH_DEC: begin
        if (dd) begin
          take_dec = 1'b1;
        end else if (sp) begin
          nxt.phase = snp_pkg::PH_TRAIL;
        end else begin
          bad = 1'b1;
        end
      end
      snp_pkg::PH_TRAIL: begin
        if (!sp) begin
          bad = 1'b1;
        end
      end
      default: begin
        bad = 1'b1;
      end
    endcase

    if (bad) begin
      nxt.error_code = snp_pkg::ST_BAD;
    end else if (take_dec) begin
      if (dec_ovf) begin
        nxt.error_code = snp_pkg::ST_DECOVF;
      end else begin
        nxt.magnitude = dec_mag;
        nxt.phase     = snp_pkg::PH_DEC;
      end
    end else if (take_hex) begin
      if (hex_ovf) begin
        nxt.error_code = snp_pkg::ST_HEXRANGE;
      end else begin
        nxt.magnitude = hex_mag;
        nxt.phase     = snp_pkg::PH_HEX;
      end
    end
  end

endmodule

/* hdl/signed64_numeral_parser_unit.sv */
// Top level of the signed 64-bit numeral parser.
//
// Takes a numeral one character per input beat (kind = 0) and closes it with
// an end beat (kind = 1), which yields one result beat: status and value.
// Grammar: optional leading whitespace, optional + or -, then decimal digits
// or a 0x / 0X prefix with hex digits, then optional trailing whitespace.
// The first error (hex out of range, decimal overflow, malformed) is latched
// and later characters are ignored; value is zero unless status is ok.
// Rate: one input beat per cycle, sustained. A character updates the parse
// state in the cycle it is accepted; an end beat lands in the output register
// and is offered in the next cycle. The input stalls only while that register
// holds a result the consumer has not taken. The per-cycle path is one
// multiply-by-ten add plus a 64-bit limit compare on the registered state.
module signed64_numeral_parser_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               kind,
  input  logic [7:0]         char_code,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [63:0] value
);

  snp_pkg::parse_state_t state;
  snp_pkg::parse_state_t state_next;
  snp_pkg::parse_state_t step_out;
  logic                  in_fire;
  logic [1:0]            end_status;
  logic [63:0]           end_value;

  // Output register frees when empty or being drained this cycle.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  snp_char_step u_step (
    .cur       (state),
    .char_code (char_code),
    .nxt       (step_out)
  );

  // Result of an end beat.
  always_comb begin
    end_status = state.error_code;
    end_value  = 64'd0;
    if (state.error_code == snp_pkg::ST_OK) begin
      if (state.phase inside {snp_pkg::PH_ZERO, snp_pkg::PH_HEX, snp_pkg::PH_DEC,
                              snp_pkg::PH_TRAIL}) begin
        end_value = state.negative ? (64'd0 - state.magnitude) : state.magnitude;
      end else begin
        end_status = snp_pkg::ST_BAD;
      end
    end
  end

  always_comb begin
    state_next = state;
    if (in_fire) begin
      if (kind == snp_pkg::KIND_END) begin
        state_next.phase      = snp_pkg::PH_LEAD;
        state_next.negative   = 1'b0;
        state_next.magnitude  = 64'd0;
        state_next.error_code = snp_pkg::ST_OK;
      end else if (state.error_code == snp_pkg::ST_OK) begin
        state_next = step_out;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase      <= snp_pkg::PH_LEAD;
      state.negative   <= 1'b0;
      state.magnitude  <= 64'd0;
      state.error_code <= snp_pkg::ST_OK;
    end else begin
      state <= state_next;
    end
  end

  // Output register: control reset, payload loaded on end beats.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && kind == snp_pkg::KIND_END) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && kind == snp_pkg::KIND_END) begin
      status <= end_status;
      value  <= end_value;
    end
  end

`ifndef NO_ASSERTIONS
  // An end beat always produces a result beat.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == snp_pkg::KIND_END |=> out_valid)
    else $error("end beat did not produce a result");

  // An end beat returns the parser to its initial state.
  a_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == snp_pkg::KIND_END |=>
      state.phase == snp_pkg::PH_LEAD && state.error_code == snp_pkg::ST_OK &&
      state.magnitude == 64'd0 && !state.negative)
    else $error("parser state not cleared after end beat");

  // A latched error survives later characters.
  a_error_latched: assert property (@(posedge clk) disable iff (rst)
    in_fire && kind == snp_pkg::KIND_CHAR && state.error_code != snp_pkg::ST_OK |=>
      state.error_code == $past(state.error_code) &&
      state.magnitude == $past(state.magnitude))
    else $error("latched error changed by a character");

  // Any failing status carries a zero value.
  a_error_zero_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != snp_pkg::ST_OK |-> value == 64'sd0)
    else $error("nonzero value with error status");
`endif

endmodule
